// ----- rtl/bctd_pkg.sv -----
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types and constants of the battery charge trend detector.
// ----------------------------------------------------------------------------
package bctd_pkg;

    localparam int unsigned MV_W    = 16;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned STALL_W = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    // Noise allowance between consecutive samples
    localparam logic [MV_W-1:0] NOISE_MV = MV_W'(3);

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [STALL_W-1:0] STALL_MAX = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_RISE_MARGIN = 2'd0,
        REG_EXIT_DROP   = 2'd1,
        REG_CONFIRM     = 2'd2,
        REG_STALL_TMO   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [MV_W-1:0]    rise_margin_mv;
        logic [MV_W-1:0]    exit_margin_mv;
        logic [CNT_W-1:0]   confirm_count;
        logic [STALL_W-1:0] stall_timeout;
    } t_cfg;

endpackage

// ----- rtl/bctd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bctd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bctd_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bctd_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [bctd_pkg::CFG_W-1:0] i_cfg_data,
    output bctd_pkg::t_cfg             o_cfg
);
    import bctd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_margin_mv <= MV_W'(20);
            r_cfg.exit_margin_mv <= MV_W'(20);
            r_cfg.confirm_count  <= CNT_W'(3);
            r_cfg.stall_timeout  <= STALL_W'(600);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_RISE_MARGIN: r_cfg.rise_margin_mv <= i_cfg_data[MV_W-1:0];
                REG_EXIT_DROP:   r_cfg.exit_margin_mv <= i_cfg_data[MV_W-1:0];
                REG_CONFIRM:     r_cfg.confirm_count  <= i_cfg_data[CNT_W-1:0];
                REG_STALL_TMO:   r_cfg.stall_timeout  <= i_cfg_data[STALL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/bctd_core.sv -----
// ----------------------------------------------------------------------------
// bctd_core
// Trend state and its single-pass update for one sample.
// ----------------------------------------------------------------------------
module bctd_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic                      i_present,
    input  logic [bctd_pkg::MV_W-1:0] i_sample,
    input  bctd_pkg::t_cfg            i_cfg,
    output logic                      o_charging
);
    import bctd_pkg::*;

    logic               r_base_valid, n_base_valid;
    logic               r_chg,        n_chg;
    logic [MV_W-1:0]    r_prev,       n_prev;
    logic [MV_W-1:0]    r_ref,        n_ref;
    logic [MV_W-1:0]    r_peak,       n_peak;
    logic [CNT_W-1:0]   r_rise,       n_rise;
    logic [CNT_W-1:0]   r_drop,       n_drop;
    logic [STALL_W-1:0] r_stall,      n_stall;

    logic [CNT_W-1:0]   confirm_eff;
    logic [STALL_W-1:0] timeout_eff;
    logic [MV_W:0]      s_wide;
    logic [MV_W:0]      s_plus_noise;
    logic [MV_W:0]      prev_plus_noise;
    logic [MV_W:0]      target;
    logic [MV_W:0]      s_plus_exit;
    logic [MV_W-1:0]    peak_upd;
    logic [CNT_W-1:0]   rise_upd;
    logic [CNT_W-1:0]   drop_upd;
    logic [STALL_W-1:0] stall_upd;

    always_comb begin
        confirm_eff = (i_cfg.confirm_count == '0) ? CNT_W'(1) : i_cfg.confirm_count;
        timeout_eff = (i_cfg.stall_timeout == '0) ? STALL_W'(1) : i_cfg.stall_timeout;

        s_wide          = {1'b0, i_sample};
        s_plus_noise    = s_wide + {1'b0, NOISE_MV};
        prev_plus_noise = {1'b0, r_prev} + {1'b0, NOISE_MV};
        target          = {1'b0, r_ref} + {1'b0, i_cfg.rise_margin_mv};
        s_plus_exit     = s_wide + {1'b0, i_cfg.exit_margin_mv};

        peak_upd  = (i_sample > r_peak) ? i_sample : r_peak;
        stall_upd = '0;
        drop_upd  = '0;
        rise_upd  = '0;

        n_base_valid = r_base_valid;
        n_chg        = r_chg;
        n_prev       = i_sample;
        n_ref        = r_ref;
        n_peak       = r_peak;
        n_rise       = r_rise;
        n_drop       = r_drop;
        n_stall      = r_stall;

        if (!i_present) begin
            // Battery gone: drop all history
            n_base_valid = 1'b0;
            n_chg        = 1'b0;
            n_prev       = '0;
            n_ref        = '0;
            n_peak       = '0;
            n_rise       = '0;
            n_drop       = '0;
            n_stall      = '0;
        end else if (!r_base_valid) begin
            n_base_valid = 1'b1;
            n_chg        = 1'b0;
            n_ref        = i_sample;
            n_peak       = i_sample;
            n_rise       = '0;
            n_drop       = '0;
            n_stall      = '0;
        end else if (!r_chg) begin
            if (i_sample < r_ref || s_plus_noise < {1'b0, r_prev}) begin
                n_ref    = i_sample;
                rise_upd = '0;
            end else if (s_wide >= target) begin
                rise_upd = (r_rise == CNT_MAX) ? r_rise : r_rise + CNT_W'(1);
            end else begin
                rise_upd = '0;
            end
            n_rise = rise_upd;
            if (rise_upd >= confirm_eff) begin
                n_chg   = 1'b1;
                n_peak  = i_sample;
                n_drop  = '0;
                n_stall = '0;
            end
        end else begin
            if (s_wide >= prev_plus_noise) begin
                stall_upd = '0;
            end else begin
                stall_upd = (r_stall == STALL_MAX) ? r_stall : r_stall + STALL_W'(1);
            end
            if (s_plus_exit <= {1'b0, peak_upd}) begin
                drop_upd = (r_drop == CNT_MAX) ? r_drop : r_drop + CNT_W'(1);
            end else begin
                drop_upd = '0;
            end
            n_peak  = peak_upd;
            n_stall = stall_upd;
            n_drop  = drop_upd;
            if (drop_upd >= confirm_eff || stall_upd >= timeout_eff) begin
                // Trend over: rebaseline on this sample
                n_chg   = 1'b0;
                n_ref   = i_sample;
                n_peak  = i_sample;
                n_rise  = '0;
                n_drop  = '0;
                n_stall = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_valid <= 1'b0;
            r_chg        <= 1'b0;
            r_prev       <= '0;
            r_ref        <= '0;
            r_peak       <= '0;
            r_rise       <= '0;
            r_drop       <= '0;
            r_stall      <= '0;
        end else if (i_advance) begin
            r_base_valid <= n_base_valid;
            r_chg        <= n_chg;
            r_prev       <= n_prev;
            r_ref        <= n_ref;
            r_peak       <= n_peak;
            r_rise       <= n_rise;
            r_drop       <= n_drop;
            r_stall      <= n_stall;
        end
    end

    assign o_charging = n_chg;

endmodule

// ----- rtl/battery_charge_trend_detector.sv -----
// ----------------------------------------------------------------------------
// battery_charge_trend_detector
// Detects a charging trend from a stream of battery voltage samples.
// ----------------------------------------------------------------------------
// Each item carries one voltage sample in mV and a battery-present flag and
// produces one result item: the charging flag after that sample. The block
// takes one item per clock cycle when the output side keeps up; an item
// passes the input register, then the result register; the state update
// between them is one pass of compares, adders and saturating counters.
// The result register lets a new item enter while a finished result still
// waits on the output. A low battery-present flag clears the whole trend
// history. Configuration registers (rise margin, exit drop, confirm count,
// stall timeout) are written through a simple write port, by the user only
// while idle (unenforced). Zero confirm count or stall timeout acts as one.
// ----------------------------------------------------------------------------
module battery_charge_trend_detector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input item channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_batt_detected,
    input  logic [bctd_pkg::MV_W-1:0]  i_sample_mv,
    // Result item channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_charging,
    // Configuration write port
    input  logic                       i_cfg_we,
    input  logic [bctd_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [bctd_pkg::CFG_W-1:0] i_cfg_data
);
    import bctd_pkg::*;

    t_cfg            cfg;

    // Input register
    logic            r_in_valid;
    logic            r_present;
    logic [MV_W-1:0] r_sample;

    // Result register
    logic            r_out_valid;
    logic            r_charging;

    logic            advance;
    logic            charging_next;

    // Process the held item whenever the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bctd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bctd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_present  (r_present),
        .i_sample   (r_sample),
        .i_cfg      (cfg),
        .o_charging (charging_next)
    );

    // Hold the accepted item until the core consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_present <= i_batt_detected;
            r_sample  <= i_sample_mv;
        end
    end

    // Load the result on advance, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_charging <= charging_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_charging  = r_charging;

endmodule
